FILE: src/double_buffered_saturating_grid_assert.svh
// Assertion macros for the double-buffered saturating grid.
// Expects clk and rst_n in the scope of the including module.
`ifndef DOUBLE_BUFFERED_SATURATING_GRID_ASSERT_SVH
`define DOUBLE_BUFFERED_SATURATING_GRID_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define DBSG_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define DBSG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dbsg_pkg.sv
// Shared types, constants and helpers of the double-buffered saturating grid.
// No dependencies; used by dbsg_seq and the top level.
package dbsg_pkg;

    // Grid geometry
    localparam int MAX_DIM = 256;
    localparam int CELLS   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W   = $clog2(CELLS + 1);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int COORD_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    // Field widths
    localparam int REQ_W      = 4;
    localparam int COORD_IN_W = 17;
    localparam int VAL_W      = 8;
    localparam int TOTAL_W    = 24;
    localparam int COUNT_W    = 17;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_W-1:0] GRID_DIM_RESET  = CFG_W'(256);
    localparam logic [VAL_W-1:0] STATS_THRESHOLD = VAL_W'(128);

    typedef enum logic [REQ_W-1:0] {
        REQ_READ      = 4'd0,
        REQ_WRITE     = 4'd1,
        REQ_ADD_SAT   = 4'd2,
        REQ_SUB_FLOOR = 4'd3,
        REQ_READ_PREV = 4'd4,
        REQ_SWAP      = 4'd5,
        REQ_CLEAR     = 4'd6,
        REQ_STATS     = 4'd7,
        REQ_COUNT     = 4'd8
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } cfg_idx_t;

    // Datapath micro-operations, one per control word
    typedef enum logic [3:0] {
        UOP_IDLE,
        UOP_CELL_RD,
        UOP_CELL_WB,
        UOP_SWAP,
        UOP_CLR_INIT,
        UOP_CLR_STEP,
        UOP_CLR_END,
        UOP_WALK_INIT,
        UOP_WALK_STEP,
        UOP_WALK_END,
        UOP_POST
    } uop_t;

    // Sequencer to datapath
    typedef struct packed {
        uop_t uop;
        logic busy;
        logic accept;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic start;
        req_t req;
        logic clr_more;
        logic walk_more;
    } seq_stat_t;

    // Dimension register saturated to the grid limit
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        if (32'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

endpackage

FILE: src/double_buffered_saturating_grid.sv
// Top level of the double-buffered saturating grid: datapath, banks, config.
// Depends on dbsg_pkg, dbsg_seq, dbsg_ram and the assertion macro header.
//
// Usage:
//   Requests: drive req_type, col, row and operand_value with start high; the
//   transaction is taken at a rising edge where busy is low. Exactly one
//   result follows, shown on cell_value, total_sum and high_count for one
//   cycle with done high. There is no back-pressure on results.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 width, 1 height) and
//   cfg_data; cfg_ready is always high. Write only while the block is idle.
// Steps, from the accepting edge to the result:
//   read, write, add, subtract, read-previous: one registered memory read,
//   then the write-back step;
//   swap and unused request codes: the result is posted with no memory access;
//   stats update and threshold count: width*height cells, one cell per
//   cycle through the memory read port;
//   clear: MAX_DIM*MAX_DIM addresses, one address of both banks per cycle.
//   A new request can be taken in the cycle the result is shown.
// Reset: busy stays high during a clearing pass while both banks are zeroed.
`include "double_buffered_saturating_grid_assert.svh"

module double_buffered_saturating_grid
    import dbsg_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         start,
    output logic                         busy,
    input  logic [REQ_W-1:0]             req_type,
    input  logic signed [COORD_IN_W-1:0] col,
    input  logic signed [COORD_IN_W-1:0] row,
    input  logic [VAL_W-1:0]             operand_value,
    // result channel
    output logic                         done,
    output logic [VAL_W-1:0]             cell_value,
    output logic [TOTAL_W-1:0]           total_sum,
    output logic [COUNT_W-1:0]           high_count,
    // configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data
);

    localparam int PROD_W  = COORD_W + DIM_W;
    localparam int NPROD_W = 2 * DIM_W;

    ctrl_t     ctrl;
    seq_stat_t seq_stat;

    // configuration
    logic [CFG_W-1:0] grid_width_reg;
    logic [CFG_W-1:0] grid_height_reg;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    // request held for the transaction
    req_t               req_reg,    req_next;
    logic               in_grid_reg, in_grid_next;
    logic [COORD_W-1:0] col_reg,    col_next;
    logic [COORD_W-1:0] row_reg,    row_next;
    logic [VAL_W-1:0]   opv_reg,    opv_next;
    logic [ADDR_W-1:0]  idx_reg,    idx_next;
    logic               req_live_reg, req_live_next;

    // walk state
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [CNT_W-1:0]   n_reg,      n_next;
    logic [VAL_W-1:0]   thr_reg,    thr_next;
    logic               pend_reg,   pend_next;
    logic [TOTAL_W-1:0] sum_reg,    sum_next;
    logic [COUNT_W-1:0] hc_reg,     hc_next;

    // architectural state
    logic               cur_b_reg,        cur_b_next;
    logic [TOTAL_W-1:0] cached_total_reg, cached_total_next;
    logic [COUNT_W-1:0] cached_high_reg,  cached_high_next;

    // result registers
    logic               done_reg,       done_next;
    logic [VAL_W-1:0]   cell_value_reg, cell_value_next;
    logic [TOTAL_W-1:0] total_sum_reg,  total_sum_next;
    logic [COUNT_W-1:0] high_count_reg, high_count_next;

    // banks
    logic               we_a;
    logic               we_b;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VAL_W-1:0]   ram_wdata;
    logic [VAL_W-1:0]   rdata_a;
    logic [VAL_W-1:0]   rdata_b;
    logic [VAL_W-1:0]   cur_data;
    logic [VAL_W-1:0]   prev_data;

    // helpers
    logic               col_ok;
    logic               row_ok;
    logic [PROD_W-1:0]  cell_prod;
    logic [ADDR_W-1:0]  cell_idx;
    logic [VAL_W:0]     add_wide;
    logic [VAL_W-1:0]   add_sat;
    logic [VAL_W-1:0]   sub_floor;
    logic [TOTAL_W:0]   sum_wide;
    logic               walk_more;
    logic               post;
    logic [VAL_W-1:0]   cell_res;
    logic               upd;
    logic [VAL_W-1:0]   new_val;

    // Sequencer
    assign seq_stat.start     = start;
    assign seq_stat.req       = req_t'(req_type);
    assign seq_stat.clr_more  = (cnt_reg != CNT_W'(CELLS - 1));
    assign seq_stat.walk_more = walk_more;

    dbsg_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (seq_stat),
        .ctrl  (ctrl)
    );

    // Cell banks
    dbsg_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_bank_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata_a)
    );

    dbsg_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_bank_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata_b)
    );

    assign cur_data  = cur_b_reg ? rdata_b : rdata_a;
    assign prev_data = cur_b_reg ? rdata_a : rdata_b;

    // Effective dimensions and grid test
    assign w_eff  = eff_dim(grid_width_reg);
    assign h_eff  = eff_dim(grid_height_reg);
    assign col_ok = !col[COORD_IN_W-1] && (32'(col[COORD_IN_W-2:0]) < 32'(w_eff));
    assign row_ok = !row[COORD_IN_W-1] && (32'(row[COORD_IN_W-2:0]) < 32'(h_eff));

    // Linear cell index: row * width + col
    assign cell_prod = PROD_W'(row_reg) * PROD_W'(w_eff);
    assign cell_idx  = ADDR_W'(cell_prod + PROD_W'(col_reg));

    // Cell arithmetic
    assign add_wide  = {1'b0, cur_data} + {1'b0, opv_reg};
    assign add_sat   = add_wide[VAL_W] ? '1 : add_wide[VAL_W-1:0];
    assign sub_floor = (cur_data <= opv_reg) ? '0 : (cur_data - opv_reg);

    // Walk accumulator, saturating
    assign sum_wide  = {1'b0, sum_reg} + (TOTAL_W + 1)'(cur_data);
    assign walk_more = (cnt_reg < n_reg);

    // Datapath driven by the current micro-op
    always_comb
    begin
        req_next          = req_reg;
        in_grid_next      = in_grid_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        opv_next          = opv_reg;
        idx_next          = idx_reg;
        req_live_next     = req_live_reg;
        cnt_next          = cnt_reg;
        n_next            = n_reg;
        thr_next          = thr_reg;
        pend_next         = pend_reg;
        sum_next          = sum_reg;
        hc_next           = hc_reg;
        cur_b_next        = cur_b_reg;
        cached_total_next = cached_total_reg;
        cached_high_next  = cached_high_reg;
        we_a              = 1'b0;
        we_b              = 1'b0;
        ram_waddr         = idx_reg;
        ram_raddr         = cell_idx;
        ram_wdata         = '0;
        post              = 1'b0;
        cell_res          = '0;
        upd               = 1'b0;
        new_val           = opv_reg;

        unique case (ctrl.uop)
            UOP_IDLE:
            begin
                if (ctrl.accept)
                begin
                    req_next      = req_t'(req_type);
                    in_grid_next  = col_ok && row_ok;
                    col_next      = col[COORD_W-1:0];
                    row_next      = row[COORD_W-1:0];
                    opv_next      = operand_value;
                    req_live_next = 1'b1;
                end
            end
            UOP_CELL_RD:
            begin
                idx_next  = cell_idx;
                ram_raddr = cell_idx;
            end
            UOP_CELL_WB:
            begin
                case (req_reg)
                    REQ_READ:      cell_res = in_grid_reg ? cur_data : '0;
                    REQ_READ_PREV: cell_res = in_grid_reg ? prev_data : '0;
                    REQ_WRITE:
                    begin
                        new_val = opv_reg;
                        upd     = in_grid_reg;
                    end
                    REQ_ADD_SAT:
                    begin
                        new_val = add_sat;
                        upd     = in_grid_reg;
                    end
                    REQ_SUB_FLOOR:
                    begin
                        new_val = sub_floor;
                        upd     = in_grid_reg;
                    end
                    default: ;
                endcase
                ram_wdata = new_val;
                we_a      = upd && !cur_b_reg;
                we_b      = upd && cur_b_reg;
                post      = 1'b1;
            end
            UOP_SWAP:
            begin
                cur_b_next = !cur_b_reg;
                post       = 1'b1;
            end
            UOP_CLR_INIT:
            begin
                cnt_next          = '0;
                cached_total_next = '0;
                cached_high_next  = '0;
            end
            UOP_CLR_STEP:
            begin
                ram_waddr = cnt_reg[ADDR_W-1:0];
                we_a      = 1'b1;
                we_b      = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            UOP_CLR_END:
            begin
                // reset's clearing pass has no transaction to answer
                post = req_live_reg;
            end
            UOP_WALK_INIT:
            begin
                cnt_next  = '0;
                sum_next  = '0;
                hc_next   = '0;
                pend_next = 1'b0;
                n_next    = CNT_W'(NPROD_W'(w_eff) * NPROD_W'(h_eff));
                thr_next  = (req_reg == REQ_STATS) ? STATS_THRESHOLD : opv_reg;
            end
            UOP_WALK_STEP:
            begin
                // issue the next read, fold in the one issued last cycle
                ram_raddr = cnt_reg[ADDR_W-1:0];
                pend_next = walk_more;
                if (walk_more)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    sum_next = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
                    if ((cur_data >= thr_reg) && (hc_reg != '1))
                    begin
                        hc_next = hc_reg + COUNT_W'(1);
                    end
                end
            end
            UOP_WALK_END:
            begin
                if (req_reg == REQ_STATS)
                begin
                    cached_total_next = sum_reg;
                    cached_high_next  = hc_reg;
                end
                post = 1'b1;
            end
            UOP_POST:
            begin
                post = 1'b1;
            end
            default: ;
        endcase

        // Result formation
        done_next       = post;
        cell_value_next = cell_value_reg;
        total_sum_next  = total_sum_reg;
        high_count_next = high_count_reg;
        if (post)
        begin
            req_live_next   = 1'b0;
            cell_value_next = cell_res;
            total_sum_next  = cached_total_next;
            high_count_next = (req_reg == REQ_COUNT) ? hc_reg : cached_high_next;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_live_reg     <= 1'b0;
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            cur_b_reg        <= 1'b0;
            cached_total_reg <= '0;
            cached_high_reg  <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            req_live_reg     <= req_live_next;
            cnt_reg          <= cnt_next;
            pend_reg         <= pend_next;
            cur_b_reg        <= cur_b_next;
            cached_total_reg <= cached_total_next;
            cached_high_reg  <= cached_high_next;
            done_reg         <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        in_grid_reg    <= in_grid_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        opv_reg        <= opv_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        thr_reg        <= thr_next;
        sum_reg        <= sum_next;
        hc_reg         <= hc_next;
        cell_value_reg <= cell_value_next;
        total_sum_reg  <= total_sum_next;
        high_count_reg <= high_count_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_DIM_RESET;
            grid_height_reg <= GRID_DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready  = 1'b1;
    assign busy       = ctrl.busy;
    assign done       = done_reg;
    assign cell_value = cell_value_reg;
    assign total_sum  = total_sum_reg;
    assign high_count = high_count_reg;

    // Checks
    `DBSG_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request not held")
    `DBSG_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
    `DBSG_ASSERT_NEXT(a_swap_flips, ctrl.uop == UOP_SWAP, $changed(cur_b_reg), "swap missed")
    `DBSG_ASSERT_NOW(a_dual_write, we_a && we_b, ctrl.uop == UOP_CLR_STEP, "dual write")

endmodule

FILE: src/dbsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dbsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/dbsg_seq.sv
// Microcoded sequencer: control ROM, step counter and jump logic.
// Depends on dbsg_pkg for the micro-op, control and status types.
module dbsg_seq
    import dbsg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  seq_stat_t stat,
    output ctrl_t     ctrl
);

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_CELL_RD   = 4'd1,
        ST_CELL_WB   = 4'd2,
        ST_SWAP      = 4'd3,
        ST_CLR_INIT  = 4'd4,
        ST_CLR       = 4'd5,
        ST_CLR_END   = 4'd6,
        ST_WALK_INIT = 4'd7,
        ST_WALK      = 4'd8,
        ST_WALK_END  = 4'd9,
        ST_POST      = 4'd10
    } step_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_DISPATCH,
        COND_LOOP_CLR,
        COND_LOOP_WALK
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t target;
    } ucode_t;

    step_t  step_reg;
    step_t  step_next;
    step_t  step_inc;
    ucode_t uw;

    // Control store
    function automatic ucode_t rom(input step_t s);
        ucode_t w;
        w = '{uop: UOP_POST, cond: COND_JUMP, target: ST_IDLE};
        unique case (s)
            ST_IDLE:      w = '{uop: UOP_IDLE,      cond: COND_DISPATCH,  target: ST_IDLE};
            ST_CELL_RD:   w = '{uop: UOP_CELL_RD,   cond: COND_NEXT,      target: ST_IDLE};
            ST_CELL_WB:   w = '{uop: UOP_CELL_WB,   cond: COND_JUMP,      target: ST_IDLE};
            ST_SWAP:      w = '{uop: UOP_SWAP,      cond: COND_JUMP,      target: ST_IDLE};
            ST_CLR_INIT:  w = '{uop: UOP_CLR_INIT,  cond: COND_NEXT,      target: ST_IDLE};
            ST_CLR:       w = '{uop: UOP_CLR_STEP,  cond: COND_LOOP_CLR,  target: ST_CLR};
            ST_CLR_END:   w = '{uop: UOP_CLR_END,   cond: COND_JUMP,      target: ST_IDLE};
            ST_WALK_INIT: w = '{uop: UOP_WALK_INIT, cond: COND_NEXT,      target: ST_IDLE};
            ST_WALK:      w = '{uop: UOP_WALK_STEP, cond: COND_LOOP_WALK, target: ST_WALK};
            ST_WALK_END:  w = '{uop: UOP_WALK_END,  cond: COND_JUMP,      target: ST_IDLE};
            ST_POST:      w = '{uop: UOP_POST,      cond: COND_JUMP,      target: ST_IDLE};
            default:      w = '{uop: UOP_POST,      cond: COND_JUMP,      target: ST_IDLE};
        endcase
        return w;
    endfunction

    // Entry point of each request's microprogram
    function automatic step_t dispatch(input req_t r);
        step_t s;
        s = ST_POST;
        case (r) inside
            REQ_READ, REQ_WRITE, REQ_ADD_SAT, REQ_SUB_FLOOR, REQ_READ_PREV: s = ST_CELL_RD;
            REQ_SWAP:             s = ST_SWAP;
            REQ_CLEAR:            s = ST_CLR_INIT;
            REQ_STATS, REQ_COUNT: s = ST_WALK_INIT;
            default:              s = ST_POST;
        endcase
        return s;
    endfunction

    assign uw       = rom(step_reg);
    assign step_inc = step_t'(step_reg + 4'd1);

    // Next step selection
    always_comb
    begin
        unique case (uw.cond)
            COND_NEXT:      step_next = step_inc;
            COND_JUMP:      step_next = uw.target;
            COND_DISPATCH:  step_next = stat.start ? dispatch(stat.req) : step_reg;
            COND_LOOP_CLR:  step_next = stat.clr_more ? uw.target : step_inc;
            COND_LOOP_WALK: step_next = stat.walk_more ? uw.target : step_inc;
            default:        step_next = ST_IDLE;
        endcase
    end

    // Step counter; reset enters the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_CLR_INIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign ctrl.uop    = uw.uop;
    assign ctrl.busy   = (step_reg != ST_IDLE);
    assign ctrl.accept = (step_reg == ST_IDLE) && stat.start;

endmodule
